// File: sv/tfp_pkg.sv
`timescale 1ns / 1ps
package tfp_pkg;

  localparam int CoordW  = 31;
  localparam int SqW     = 64;
  localparam int RootW   = 32;
  localparam int XW      = 33;
  localparam int NumW    = 65;
  localparam int DivW    = 34;
  localparam int IsqSteps = 32;
  localparam int DivSteps = 65;
  localparam int InDataW  = 280;
  localparam int OutDataW = 104;

  typedef struct packed {
    logic [SqW-1:0]   s_ab;
    logic [SqW-1:0]   s_ac;
    logic [SqW-1:0]   s_cb;
    logic             neg;
    logic [XW-1:0]    x;
    logic [RootW-1:0] len;
    logic             degen;
  } tfp_side_t;

endpackage

// File: sv/triangle_flatten_to_plane_top.sv
`timescale 1ns / 1ps
// Triangle flattening pipeline.
// Slave channel (s_*): one item is one triangle, corners A, B, C as signed
// Q15.16 coordinates. Master channel (m_*): one item per triangle with B's
// flattened x (signed) and y, C's x (the length AC), and tuser[0] set when
// A and C coincide, in which case all data fields are zero.
// Throughput: one item per cycle while the pipeline is not stalled. Items pass
// through the squaring stages, the two 32-stage square root pipelines, the 65-stage
// divider and the numerator, saturation and output stages.
// The whole pipeline advances together; when the receiver holds m_tready
// low with a result waiting, every stage holds and s_tready drops, so no
// item is lost or repeated. Reset empties the pipeline; no item is pending
// afterwards and no setup is needed.
module triangle_flatten_to_plane_top
  import tfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (31 bits each), zero pad
  input  logic [InDataW-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // flat_b_x (33), flat_b_y (32), flat_c_x (32), zero pad
  output logic [OutDataW-1:0] m_tdata,
  // degenerate
  output logic [0:0]          m_tuser
);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic signed [CoordW-1:0] ca [3];
  logic signed [CoordW-1:0] cb [3];
  logic signed [CoordW-1:0] cc [3];
  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign ca[k] = s_tdata[k*CoordW +: CoordW];
    assign cb[k] = s_tdata[(k+3)*CoordW +: CoordW];
    assign cc[k] = s_tdata[(k+6)*CoordW +: CoordW];
  end

  logic           sq_vld;
  logic [SqW-1:0] s_ab, s_ac, s_cb;

  tfp_sqd u_sqd (
    .clk(clk), .rst(rst), .en(en), .in_vld(s_tvalid && s_tready),
    .a(ca), .b(cb), .c(cc),
    .out_vld(sq_vld), .s_ab(s_ab), .s_ac(s_ac), .s_cb(s_cb)
  );

  tfp_side_t side0;
  always_comb begin
    side0       = '0;
    side0.s_ab  = s_ab;
    side0.s_ac  = s_ac;
    side0.s_cb  = s_cb;
    side0.degen = (s_ac == '0);
  end

  logic             r1_vld;
  logic [RootW-1:0] r1_root;
  tfp_side_t        r1_side;

  tfp_isqrt u_sqrt_ac (
    .clk(clk), .rst(rst), .en(en), .in_vld(sq_vld), .in_rad(s_ac), .in_side(side0),
    .out_vld(r1_vld), .out_root(r1_root), .out_side(r1_side)
  );

  // numerator s_ab + s_ac - s_cb as sign and magnitude
  logic            nm_vld;
  logic [NumW-1:0] nm_mag;
  tfp_side_t       nm_side;
  tfp_side_t       nm_side_next;
  logic [NumW-1:0] nsum;
  assign nsum = NumW'(r1_side.s_ab) + NumW'(r1_side.s_ac);

  always_comb begin
    nm_side_next     = r1_side;
    nm_side_next.len = r1_root;
    nm_side_next.neg = (nsum < NumW'(r1_side.s_cb));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_vld <= 1'b0;
    end else if (en) begin
      nm_vld <= r1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_side <= nm_side_next;
      if (nm_side_next.neg) begin
        nm_mag <= NumW'(r1_side.s_cb) - nsum;
      end else begin
        nm_mag <= nsum - NumW'(r1_side.s_cb);
      end
    end
  end

  logic            dv_vld;
  logic [NumW-1:0] dv_quo;
  tfp_side_t       dv_side;

  tfp_div u_div (
    .clk(clk), .rst(rst), .en(en), .in_vld(nm_vld), .in_num(nm_mag), .in_side(nm_side),
    .out_vld(dv_vld), .out_quo(dv_quo), .out_side(dv_side)
  );

  // saturate quotient, then square it, then form the radicand
  localparam logic [NumW-1:0] PosMax = NumW'(33'h0_FFFF_FFFF);
  localparam logic [NumW-1:0] NegMax = NumW'(33'h1_0000_0000);

  logic          st_vld, ml_vld, df_vld;
  logic [XW-1:0] st_mag;
  tfp_side_t     st_side, ml_side, df_side;
  tfp_side_t     st_side_next;
  logic [SqW-1:0] ml_x2, df_rad;
  logic           ml_big;

  always_comb begin
    st_side_next = dv_side;
    if (dv_side.neg) begin
      st_side_next.x = (dv_quo > NegMax) ? XW'(-NegMax[XW-1:0]) : XW'(-dv_quo[XW-1:0]);
    end else begin
      st_side_next.x = (dv_quo > PosMax) ? PosMax[XW-1:0] : dv_quo[XW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld <= 1'b0;
      ml_vld <= 1'b0;
      df_vld <= 1'b0;
    end else if (en) begin
      st_vld <= dv_vld;
      ml_vld <= st_vld;
      df_vld <= ml_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_side <= st_side_next;
      if (dv_side.neg) begin
        st_mag <= (dv_quo > NegMax) ? NegMax[XW-1:0] : dv_quo[XW-1:0];
      end else begin
        st_mag <= (dv_quo > PosMax) ? PosMax[XW-1:0] : dv_quo[XW-1:0];
      end

      ml_side <= st_side;
      ml_big  <= st_mag[XW-1];
      ml_x2   <= st_mag[XW-2:0] * st_mag[XW-2:0];

      df_side <= ml_side;
      if (ml_big) begin
        df_rad <= (ml_side.s_ab == '0) ? '1 : SqW'(-ml_side.s_ab);
      end else if (ml_side.s_ab >= ml_x2) begin
        df_rad <= ml_side.s_ab - ml_x2;
      end else begin
        df_rad <= ml_x2 - ml_side.s_ab;
      end
    end
  end

  logic             r2_vld;
  logic [RootW-1:0] r2_root;
  tfp_side_t        r2_side;

  tfp_isqrt u_sqrt_y (
    .clk(clk), .rst(rst), .en(en), .in_vld(df_vld), .in_rad(df_rad), .in_side(df_side),
    .out_vld(r2_vld), .out_root(r2_root), .out_side(r2_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= r2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser[0] <= r2_side.degen;
      if (r2_side.degen) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {7'd0, r2_side.len, r2_root, r2_side.x};
      end
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("degenerate item carries nonzero data");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_ready: assert property (@(posedge clk)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow pipeline advance");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

// File: sv/tfp_sqd.sv
`timescale 1ns / 1ps
module tfp_sqd
  import tfp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic signed [CoordW-1:0] a [3],
  input  logic signed [CoordW-1:0] b [3],
  input  logic signed [CoordW-1:0] c [3],
  output logic                    out_vld,
  output logic [SqW-1:0]          s_ab,
  output logic [SqW-1:0]          s_ac,
  output logic [SqW-1:0]          s_cb
);

  // stage 1: absolute edge vector components, stage 2: squares, stage 3: sums
  logic [31:0] m_ab [3];
  logic [31:0] m_ac [3];
  logic [31:0] m_cb [3];
  logic [62:0] q_ab [3];
  logic [62:0] q_ac [3];
  logic [62:0] q_cb [3];
  logic        vld1, vld2;

  function automatic logic [31:0] absdiff(input logic signed [CoordW-1:0] p,
                                          input logic signed [CoordW-1:0] q);
    logic signed [31:0] d;
    d = 32'(p) - 32'(q);
    return d[31] ? 32'(-d) : 32'(d);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m_ab[k] <= absdiff(b[k], a[k]);
        m_ac[k] <= absdiff(c[k], a[k]);
        m_cb[k] <= absdiff(b[k], c[k]);
        q_ab[k] <= 63'(m_ab[k] * m_ab[k]);
        q_ac[k] <= 63'(m_ac[k] * m_ac[k]);
        q_cb[k] <= 63'(m_cb[k] * m_cb[k]);
      end
      s_ab <= SqW'(q_ab[0]) + SqW'(q_ab[1]) + SqW'(q_ab[2]);
      s_ac <= SqW'(q_ac[0]) + SqW'(q_ac[1]) + SqW'(q_ac[2]);
      s_cb <= SqW'(q_cb[0]) + SqW'(q_cb[1]) + SqW'(q_cb[2]);
    end
  end

endmodule

// File: sv/tfp_isqrt.sv
`timescale 1ns / 1ps
module tfp_isqrt
  import tfp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [SqW-1:0]   in_rad,
  input  tfp_side_t        in_side,
  output logic             out_vld,
  output logic [RootW-1:0] out_root,
  output tfp_side_t        out_side
);

  // one result bit per stage, bit weight 4^(31-k)
  logic [SqW-1:0] n_r   [1:IsqSteps];
  logic [SqW-1:0] res_r [1:IsqSteps];
  logic           vld_r [1:IsqSteps];
  tfp_side_t      side_r [1:IsqSteps];

  for (genvar k = 0; k < IsqSteps; k++) begin : g_st
    localparam logic [SqW-1:0] Bit = SqW'(1) << (SqW - 2 - 2 * k);
    logic [SqW-1:0] n_in, res_in, t;
    logic           v_in;
    tfp_side_t      s_in;
    if (k == 0) begin : g_first
      assign n_in   = in_rad;
      assign res_in = '0;
      assign v_in   = in_vld;
      assign s_in   = in_side;
    end else begin : g_rest
      assign n_in   = n_r[k];
      assign res_in = res_r[k];
      assign v_in   = vld_r[k];
      assign s_in   = side_r[k];
    end
    assign t = res_in + Bit;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k+1] <= s_in;
        if (n_in >= t) begin
          n_r[k+1]   <= n_in - t;
          res_r[k+1] <= (res_in >> 1) + Bit;
        end else begin
          n_r[k+1]   <= n_in;
          res_r[k+1] <= res_in >> 1;
        end
      end
    end
  end

  assign out_vld  = vld_r[IsqSteps];
  assign out_root = res_r[IsqSteps][RootW-1:0];
  assign out_side = side_r[IsqSteps];

endmodule

// File: sv/tfp_div.sv
`timescale 1ns / 1ps
module tfp_div
  import tfp_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [NumW-1:0] in_num,
  input  tfp_side_t       in_side,
  output logic            out_vld,
  output logic [NumW-1:0] out_quo,
  output tfp_side_t       out_side
);

  // restoring division by 2*len, one quotient bit per stage, msb first
  logic [NumW-1:0] num_r  [1:DivSteps];
  logic [NumW-1:0] quo_r  [1:DivSteps];
  logic [DivW-1:0] rem_r  [1:DivSteps];
  logic            vld_r  [1:DivSteps];
  tfp_side_t       side_r [1:DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_st
    logic [NumW-1:0] num_in, quo_in;
    logic [DivW-1:0] rem_in, dv;
    logic [DivW:0]   rs;
    logic            v_in;
    tfp_side_t       s_in;
    if (k == 0) begin : g_first
      assign num_in = in_num;
      assign quo_in = '0;
      assign rem_in = '0;
      assign v_in   = in_vld;
      assign s_in   = in_side;
    end else begin : g_rest
      assign num_in = num_r[k];
      assign quo_in = quo_r[k];
      assign rem_in = rem_r[k];
      assign v_in   = vld_r[k];
      assign s_in   = side_r[k];
    end
    assign dv = {1'b0, s_in.len, 1'b0};
    assign rs = {rem_in, num_in[NumW-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k+1] <= s_in;
        num_r[k+1]  <= num_in << 1;
        if (rs >= {1'b0, dv}) begin
          rem_r[k+1] <= DivW'(rs - {1'b0, dv});
          quo_r[k+1] <= {quo_in[NumW-2:0], 1'b1};
        end else begin
          rem_r[k+1] <= rs[DivW-1:0];
          quo_r[k+1] <= {quo_in[NumW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vld_r[DivSteps];
  assign out_quo  = quo_r[DivSteps];
  assign out_side = side_r[DivSteps];

endmodule
